// ----- rtl/kcq_pkg.sv -----
// Shared types, codes and constants of the keyframe channel query unit.
`timescale 1ns / 1ps
package kcq_pkg;

    localparam int FRAMES_DEF      = 256;
    localparam int MAX_ENTRIES_DEF = 63;
    localparam int OFFSET_BITS_DEF = 24;

    // Frame index and count width (frame_count register width).
    localparam int CNT_W = 9;
    // Frame time width: a periodic time is index * period.
    localparam int T_W   = 32 + CNT_W;

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_SAMPLE  = 3'd1;
    localparam logic [2:0] OP_EVT_AT  = 3'd2;
    localparam logic [2:0] OP_EVT_BTW = 3'd3;
    localparam logic [2:0] OP_EXTREME = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_GENERIC = 2'd2;

    localparam logic [2:0] REG_APERIODIC = 3'd0;
    localparam logic [2:0] REG_PERIOD    = 3'd1;
    localparam logic [2:0] REG_COUNT     = 3'd2;
    localparam logic [2:0] REG_EVENT     = 3'd3;
    localparam logic [2:0] REG_MAX       = 3'd4;

    typedef struct packed {
        logic             aperiodic;
        logic [31:0]      period;
        logic [CNT_W-1:0] nframes;
        logic             event_ch;
        logic [5:0]       cap;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       st;
        logic [7:0]       bf;
        logic [7:0]       nf;
        logic             use_ratio;
        logic             use_evt;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } t_item;

    typedef struct packed {
        logic             wr;
        logic             ld_in;
        logic             rd;
        logic [CNT_W-1:0] rd_idx;
        logic             set_t;
        logic             set_prev;
        logic             div_start;
        logic             emit;
        t_item            item;
    } t_cmd;

    typedef struct packed {
        logic qt_gt_ft;
        logic qe_gt_ft;
        logic qt_eq_qe;
        logic qt_lt_qe;
        logic ft_le_qt;
        logic ft_lt_qe;
        logic ft_ge_qt;
        logic ft_gt_qe;
        logic ft_eq_qt;
        logic ft_gt_t;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/kcq_datapath.sv -----
// Datapath: frame memories, frame time fetch, ratio divider and result register.
`timescale 1ns / 1ps
module kcq_datapath #(
    parameter int FRAMES      = kcq_pkg::FRAMES_DEF,
    parameter int OFFSET_BITS = kcq_pkg::OFFSET_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kcq_pkg::t_cfg                 i_cfg,
    input  kcq_pkg::t_cmd                 i_cmd,
    input  logic [7:0]                    i_frame_index,
    input  logic [31:0]                   i_load_time,
    input  logic [OFFSET_BITS-1:0]        i_event_offset,
    input  logic [31:0]                   i_query_time,
    input  logic [31:0]                   i_query_end,
    output kcq_pkg::t_sts                 o_sts,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [75+OFFSET_BITS-1:0]     o_data,
    output logic                          o_last
);
    import kcq_pkg::*;

    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [31:0]            mem_t [FRAMES];
    logic [OFFSET_BITS-1:0] mem_o [FRAMES];

    logic [31:0]            r_mt;
    logic [OFFSET_BITS-1:0] r_mo;
    logic [T_W-1:0]         r_prod;
    logic [31:0]            r_qt;
    logic [31:0]            r_qe;
    logic [T_W-1:0]         r_t;
    logic [T_W-1:0]         r_prev;
    logic [T_W-1:0]         r_rem;
    logic [T_W-1:0]         r_dvs;
    logic [15:0]            r_q;
    logic [4:0]             r_dc;
    logic                   r_ovalid;
    logic [75+OFFSET_BITS-1:0] r_odata;
    logic                   r_olast;

    logic [T_W-1:0] ft;
    logic [T_W-1:0] qt_x;
    logic [T_W-1:0] qe_x;
    logic [T_W:0]   shifted;
    logic           out_free;

    assign ft   = i_cfg.aperiodic ? T_W'(r_mt) : r_prod;
    assign qt_x = T_W'(r_qt);
    assign qe_x = T_W'(r_qe);
    assign shifted = {r_rem, 1'b0};
    assign out_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (32'(i_frame_index) < FRAMES)) begin
            mem_t[AW'(i_frame_index)] <= i_load_time;
            mem_o[AW'(i_frame_index)] <= i_event_offset;
        end
        if (i_cmd.rd) begin
            r_mt   <= mem_t[AW'(i_cmd.rd_idx)];
            r_mo   <= mem_o[AW'(i_cmd.rd_idx)];
            r_prod <= T_W'(i_cmd.rd_idx) * T_W'(i_cfg.period);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_qt <= i_query_time;
            r_qe <= i_query_end;
        end
        if (i_cmd.set_t) begin
            r_t <= (qt_x < ft) ? ft : qt_x;
        end
        if (i_cmd.set_t || i_cmd.set_prev) begin
            r_prev <= ft;
        end
    end

    // Restoring division: remainder stays below the divisor, one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc <= 5'd0;
        end else if (i_cmd.div_start) begin
            r_dc <= 5'd16;
        end else if (r_dc != 5'd0) begin
            r_dc <= r_dc - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= r_t - r_prev;
            r_dvs <= ft - r_prev;
            r_q   <= 16'd0;
        end else if (r_dc != 5'd0) begin
            if (shifted >= {1'b0, r_dvs}) begin
                r_rem <= T_W'(shifted - {1'b0, r_dvs});
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= T_W'(shifted);
                r_q   <= {r_q[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= {i_cmd.item.cnt,
                        i_cmd.item.use_evt ? r_mo : {OFFSET_BITS{1'b0}},
                        i_cmd.item.use_evt ? ft[31:0] : 32'd0,
                        i_cmd.item.use_ratio ? r_q : 16'd0,
                        i_cmd.item.nf, i_cmd.item.bf, i_cmd.item.st};
            r_olast <= i_cmd.item.last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;

    always_comb begin
        o_sts.qt_gt_ft = qt_x > ft;
        o_sts.qe_gt_ft = qe_x > ft;
        o_sts.qt_eq_qe = r_qt == r_qe;
        o_sts.qt_lt_qe = r_qt < r_qe;
        o_sts.ft_le_qt = ft <= qt_x;
        o_sts.ft_lt_qe = ft < qe_x;
        o_sts.ft_ge_qt = ft >= qt_x;
        o_sts.ft_gt_qe = ft > qe_x;
        o_sts.ft_eq_qt = ft == qt_x;
        o_sts.ft_gt_t  = ft > r_t;
        o_sts.div_busy = r_dc != 5'd0;
        o_sts.out_free = out_free;
    end

endmodule

// ----- rtl/kcq_ctrl.sv -----
// Controller: sequences frame scans, the ratio divide and result words per query.
`timescale 1ns / 1ps
module kcq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kcq_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_op,
    input  logic          i_at_end,
    input  kcq_pkg::t_sts i_sts,
    output kcq_pkg::t_cmd o_cmd
);
    import kcq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DUR_RD   = 4'd1;
    localparam logic [3:0] S_DUR_CHK  = 4'd2;
    localparam logic [3:0] S_F0_RD    = 4'd3;
    localparam logic [3:0] S_F0_CHK   = 4'd4;
    localparam logic [3:0] S_SCAN_RD  = 4'd5;
    localparam logic [3:0] S_SCAN_CHK = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_LIST_SET = 4'd8;
    localparam logic [3:0] S_LIST_RD  = 4'd9;
    localparam logic [3:0] S_LIST_CHK = 4'd10;
    localparam logic [3:0] S_EMIT     = 4'd11;

    logic [3:0]       r_state, n_state;
    logic [3:0]       r_ret, n_ret;
    t_item            r_em, n_em;
    logic [2:0]       r_op, n_op;
    logic             r_desc, n_desc;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_b, n_b;
    logic [CNT_W-1:0] r_nx, n_nx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_st, n_st;
    logic [5:0]       r_k, n_k;

    logic [CNT_W-1:0] nfr;
    logic [CNT_W-1:0] last_idx;
    logic             scan_done;

    function automatic t_item f_item(input logic [1:0] st, input logic [7:0] bf,
                                     input logic [7:0] nf, input logic ur,
                                     input logic ue, input logic [CNT_W-1:0] cnt,
                                     input logic last);
        t_item it;
        it.st        = st;
        it.bf        = bf;
        it.nf        = nf;
        it.use_ratio = ur;
        it.use_evt   = ue;
        it.cnt       = cnt;
        it.last      = last;
        return it;
    endfunction

    assign nfr       = i_cfg.nframes;
    assign last_idx  = nfr - CNT_W'(1);
    assign scan_done = r_desc ? (r_i == '0) : (r_i >= nfr);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_em    = r_em;
        n_op    = r_op;
        n_desc  = r_desc;
        n_i     = r_i;
        n_b     = r_b;
        n_nx    = r_nx;
        n_cnt   = r_cnt;
        n_st    = r_st;
        n_k     = r_k;
        o_cmd   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_op   = i_op;
                    n_desc = 1'b0;
                    n_ret  = S_IDLE;
                    case (i_op)
                        OP_LOAD: begin
                            o_cmd.wr = 1'b1;
                        end
                        OP_SAMPLE: begin
                            if (nfr == '0) begin
                                n_em    = f_item(ST_INVALID, 8'd0, 8'd0, 1'b0, 1'b0, '0, 1'b1);
                                n_state = S_EMIT;
                            end else begin
                                n_i     = last_idx;
                                n_state = S_DUR_RD;
                            end
                        end
                        OP_EVT_AT: begin
                            if (!i_cfg.event_ch) begin
                                n_em    = f_item(ST_GENERIC, 8'd0, 8'd0, 1'b0, 1'b0, '0, 1'b1);
                                n_state = S_EMIT;
                            end else begin
                                n_i     = '0;
                                n_cnt   = '0;
                                n_st    = ST_OK;
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_EVT_BTW: begin
                            if (!i_cfg.event_ch) begin
                                n_em    = f_item(ST_GENERIC, 8'd0, 8'd0, 1'b0, 1'b0, '0, 1'b1);
                                n_state = S_EMIT;
                            end else if (nfr == '0) begin
                                n_em    = f_item(ST_INVALID, 8'd0, 8'd0, 1'b0, 1'b0, '0, 1'b1);
                                n_state = S_EMIT;
                            end else begin
                                n_i     = last_idx;
                                n_state = S_DUR_RD;
                            end
                        end
                        OP_EXTREME: begin
                            if (nfr == '0) begin
                                n_em = f_item(ST_GENERIC, 8'd0, 8'd0, 1'b0, 1'b0, '0, 1'b1);
                            end else begin
                                n_em = f_item(ST_OK, i_at_end ? 8'(last_idx) : 8'd0, 8'd0,
                                              1'b0, 1'b0, '0, 1'b1);
                            end
                            n_state = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUR_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_idx = r_i;
                n_state      = S_DUR_CHK;
            end
            S_DUR_CHK: begin
                if (r_op == OP_SAMPLE) begin
                    if (i_sts.qt_gt_ft) begin
                        n_em    = f_item(ST_INVALID, 8'd0, 8'd0, 1'b0, 1'b0, '0, 1'b1);
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_F0_RD;
                    end
                end else begin
                    if (i_sts.qt_gt_ft || i_sts.qe_gt_ft || i_sts.qt_eq_qe) begin
                        n_em    = f_item(ST_INVALID, 8'd0, 8'd0, 1'b0, 1'b0, '0, 1'b1);
                        n_state = S_EMIT;
                    end else if (i_sts.qt_lt_qe) begin
                        // Ascending: bounds are kept as index plus one.
                        n_desc  = 1'b0;
                        n_i     = '0;
                        n_b     = '0;
                        n_nx    = '0;
                        n_state = S_SCAN_RD;
                    end else begin
                        // Descending: the scan counter runs one above the frame it reads.
                        n_desc  = 1'b1;
                        n_i     = nfr;
                        n_b     = nfr;
                        n_nx    = nfr;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_F0_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_idx = '0;
                n_state      = S_F0_CHK;
            end
            S_F0_CHK: begin
                o_cmd.set_t = 1'b1;
                n_i         = CNT_W'(1);
                n_state     = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (scan_done) begin
                    case (r_op)
                        OP_SAMPLE: begin
                            n_em    = f_item(ST_OK, 8'(last_idx), 8'(last_idx),
                                             1'b0, 1'b0, '0, 1'b1);
                            n_state = S_EMIT;
                        end
                        OP_EVT_AT: begin
                            n_em    = f_item(r_st, 8'd0, 8'd0, 1'b0, 1'b0, r_cnt, 1'b1);
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_LIST_SET;
                        end
                    endcase
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_idx = r_desc ? r_i - CNT_W'(1) : r_i;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                n_state = S_SCAN_RD;
                case (r_op)
                    OP_SAMPLE: begin
                        if (i_sts.ft_gt_t) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end else begin
                            o_cmd.set_prev = 1'b1;
                            n_i            = r_i + CNT_W'(1);
                        end
                    end
                    OP_EVT_AT: begin
                        n_i = r_i + CNT_W'(1);
                        if (i_sts.ft_eq_qt) begin
                            n_cnt = r_cnt + CNT_W'(1);
                            if (r_cnt < CNT_W'(i_cfg.cap)) begin
                                n_em    = f_item(ST_OK, 8'(r_i), 8'd0, 1'b0, 1'b1, '0, 1'b0);
                                n_ret   = S_SCAN_RD;
                                n_state = S_EMIT;
                            end else begin
                                n_st = ST_GENERIC;
                            end
                        end
                    end
                    default: begin
                        if (!r_desc) begin
                            if (i_sts.ft_le_qt) begin
                                n_b = r_i + CNT_W'(1);
                            end
                            if (i_sts.ft_lt_qe) begin
                                n_nx = r_i + CNT_W'(1);
                                n_i  = r_i + CNT_W'(1);
                            end else begin
                                n_state = S_LIST_SET;
                            end
                        end else begin
                            if (i_sts.ft_ge_qt) begin
                                n_b = r_i - CNT_W'(1);
                            end
                            if (i_sts.ft_gt_qe) begin
                                n_nx = r_i - CNT_W'(1);
                                n_i  = r_i - CNT_W'(1);
                            end else begin
                                n_state = S_LIST_SET;
                            end
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_em    = f_item(ST_OK, 8'(r_i - CNT_W'(1)), 8'(r_i), 1'b1, 1'b0, '0, 1'b1);
                    n_ret   = S_IDLE;
                    n_state = S_EMIT;
                end
            end
            S_LIST_SET: begin
                n_k = '0;
                if (!r_desc) begin
                    n_cnt = (r_nx > r_b) ? r_nx - r_b : '0;
                    n_i   = r_b;
                end else begin
                    n_cnt = (r_b > r_nx) ? r_b - r_nx : '0;
                    n_i   = r_b - CNT_W'(1);
                end
                n_state = S_LIST_RD;
            end
            S_LIST_RD: begin
                if ((CNT_W'(r_k) >= r_cnt) || (r_k >= i_cfg.cap)) begin
                    n_em    = f_item(ST_OK, 8'd0, 8'd0, 1'b0, 1'b0, r_cnt, 1'b1);
                    n_ret   = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_idx = r_i;
                    n_state      = S_LIST_CHK;
                end
            end
            S_LIST_CHK: begin
                n_em    = f_item(ST_OK, 8'(r_i), 8'd0, 1'b0, 1'b1, '0, 1'b0);
                n_ret   = S_LIST_RD;
                n_state = S_EMIT;
                n_k     = r_k + 6'd1;
                n_i     = r_desc ? r_i - CNT_W'(1) : r_i + CNT_W'(1);
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = r_ret;
                    n_ret      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.item = r_em;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_ff @(posedge i_clk) begin
        r_em   <= n_em;
        r_op   <= n_op;
        r_desc <= n_desc;
        r_i    <= n_i;
        r_b    <= n_b;
        r_nx   <= n_nx;
        r_cnt  <= n_cnt;
        r_st   <= n_st;
        r_k    <= n_k;
    end

endmodule

// ----- rtl/keyframe_channel_query_unit.sv -----
// A load goes straight into the frame memories; a query holds the input until its last word
// is in the output register. Frame reads are registered, so each frame walked takes a read state
// and a check state. A sample checks the last frame, reads frame 0, scans to its upper frame and
// runs the restoring divide, skipped at the last frame. Events at a time scan all frames and list
// each match; events between scan to the query end, then list words; extreme queries read none.
// Synchronous active-low reset clears control and configuration state, not the frame memories.
`timescale 1ns / 1ps
module keyframe_channel_query_unit #(
    parameter int FRAMES      = kcq_pkg::FRAMES_DEF,
    parameter int MAX_ENTRIES = kcq_pkg::MAX_ENTRIES_DEF,
    parameter int OFFSET_BITS = kcq_pkg::OFFSET_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // frame_index, load_time, event_offset, query_time, query_end, at_end
    input  logic [((105+OFFSET_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, base_frame, next_frame, ratio, event_time, event_data_offset, event_count
    output logic [((75+OFFSET_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import kcq_pkg::*;

    localparam int OUT_W = ((75 + OFFSET_BITS + 7) / 8) * 8;
    localparam int OFF_LO = 40;
    localparam int QT_LO  = 40 + OFFSET_BITS;

    logic             r_aperiodic;
    logic [31:0]      r_period;
    logic [CNT_W-1:0] r_count;
    logic             r_event;
    logic [5:0]       r_max;

    t_cfg cfg;
    t_cmd ctrl_cmd;
    t_sts dp_sts;
    logic [75+OFFSET_BITS-1:0] dp_data;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aperiodic <= 1'b0;
            r_period    <= 32'd0;
            r_count     <= '0;
            r_event     <= 1'b0;
            r_max       <= 6'd0;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_APERIODIC: r_aperiodic <= pwdata[0];
                REG_PERIOD:    r_period    <= pwdata;
                REG_COUNT:     r_count     <= pwdata[CNT_W-1:0];
                REG_EVENT:     r_event     <= pwdata[0];
                REG_MAX:       r_max       <= pwdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_APERIODIC: prdata = {31'd0, r_aperiodic};
            REG_PERIOD:    prdata = r_period;
            REG_COUNT:     prdata = 32'(r_count);
            REG_EVENT:     prdata = {31'd0, r_event};
            REG_MAX:       prdata = {26'd0, r_max};
            default:       prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.aperiodic = r_aperiodic;
        cfg.period    = r_period;
        cfg.nframes   = (32'(r_count) > FRAMES) ? CNT_W'(FRAMES) : r_count;
        cfg.event_ch  = r_event;
        cfg.cap       = (32'(r_max) > MAX_ENTRIES) ? 6'(MAX_ENTRIES) : r_max;
    end

    kcq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_at_end   (s_axis_tdata[QT_LO+64]),
        .i_sts      (dp_sts),
        .o_cmd      (ctrl_cmd)
    );

    kcq_datapath #(
        .FRAMES      (FRAMES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (ctrl_cmd),
        .i_frame_index  (s_axis_tdata[7:0]),
        .i_load_time    (s_axis_tdata[39:8]),
        .i_event_offset (s_axis_tdata[OFF_LO +: OFFSET_BITS]),
        .i_query_time   (s_axis_tdata[QT_LO +: 32]),
        .i_query_end    (s_axis_tdata[QT_LO+32 +: 32]),
        .o_sts          (dp_sts),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_data         (dp_data),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'(dp_data);

    // The divider only runs while a sample query holds off new words.
    a_div_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_sts.div_busy |-> !s_axis_tready)
        else $error("divider busy while input is open");

    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.div_start |=> dp_sts.div_busy)
        else $error("divider did not start");

    a_query_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready &&
         (s_axis_tuser == OP_SAMPLE || s_axis_tuser == OP_EVT_AT ||
          s_axis_tuser == OP_EVT_BTW || s_axis_tuser == OP_EXTREME)) |=> !s_axis_tready)
        else $error("input reopened before query finished");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result word overwritten");

endmodule
